FILE: rtl/radix_digit_converter_defines.svh
// Assertion macros for the radix digit converter.
// Included by the top level; depends on nothing else.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdc: next-cycle check failed");

`endif

FILE: rtl/rdc_pkg.sv
// Shared types, constants and the digit-to-ASCII mapping of the radix converter.
// No dependencies.
`default_nettype none

package rdc_pkg;

   localparam int BaseWidth       = 6;
   localparam int DigitWidth      = 6;
   localparam int CharWidth       = 8;
   localparam int DigitCountWidth = 7;
   localparam int QueueDepth      = 2;
   localparam int QueuePtrWidth   = 1;

   localparam logic [BaseWidth-1:0]  MinBase = 6'd2;
   localparam logic [BaseWidth-1:0]  MaxBase = 6'd36;
   localparam logic [DigitWidth-1:0] Ten     = 6'd10;
   localparam logic [CharWidth-1:0]  Char0   = 8'h30;
   localparam logic [CharWidth-1:0]  Char9   = 8'h39;
   localparam logic [CharWidth-1:0]  CharA   = 8'h41;
   localparam logic [CharWidth-1:0]  CharZ   = 8'h5A;

   // item class decided at the front
   typedef enum logic [1:0] {
      KIND_BAD,
      KIND_ZERO,
      KIND_CONVERT
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [BaseWidth-1:0] base;
   } tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_LOAD
   } state_type;

   function automatic logic [CharWidth-1:0] digit_to_ascii(input logic [DigitWidth-1:0] d);
      logic [CharWidth-1:0] dx;
      dx = {{(CharWidth-DigitWidth){1'b0}}, d};
      if (d >= Ten) begin
         return CharA + dx - {{(CharWidth-DigitWidth){1'b0}}, Ten};
      end
      return Char0 + dx;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/radix_digit_converter.sv
// Top level of the radix digit converter: front classifier/queue and back converter.
// Depends on rdc_pkg, rdc_front, rdc_back and radix_digit_converter_defines.svh.
`default_nettype none
`include "radix_digit_converter_defines.svh"

//  channel   dir  handshake              payload
//  req_      in   req_valid / req_stall  req_number, req_base
//  rsp_      out  rsp_valid / rsp_stall  rsp_digit_char, rsp_last, rsp_digit_count,
//                                        rsp_bad_base
//
// Sequence: each digit is one full pass of the bit-serial divider over the number's
//   bits, then each character passes through a stack read (ST_READ) and an output load
//   (ST_LOAD). Zero skips the divider; a bad base is answered directly from the queue.
// Reset: synchronous, active high; clears the queue, the state machine, the output
//   valid and the held digit count. The digit stack needs no clearing.
// Stalls: the two-entry queue takes new numbers while the back end works;
//   rsp_stall holds the output register and pauses the emitter and bad-base answers;
//   the divider runs on.

module radix_digit_converter import rdc_pkg::*; #(
   parameter int MAX_DIGITS   = 64,
   parameter int NUMBER_WIDTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [NUMBER_WIDTH-1:0] req_number,
   input  wire logic [BaseWidth-1:0]    req_base,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [CharWidth-1:0]         rsp_digit_char,
   output logic                         rsp_last,
   output logic [DigitCountWidth-1:0]   rsp_digit_count,
   output logic                         rsp_bad_base
);

   // queue to converter
   logic                    q_valid;
   tag_type                 q_tag;
   logic [NUMBER_WIDTH-1:0] q_number;
   logic                    q_pop;

   // assertion terms
   logic bad_form_ok;
   logic digit_char_ok;
   logic good_char_ok;

   rdc_front #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .req_base   (req_base),
      .q_valid    (q_valid),
      .q_tag      (q_tag),
      .q_number   (q_number),
      .q_pop      (q_pop)
   );

   rdc_back #(
      .MAX_DIGITS   (MAX_DIGITS),
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_tag           (q_tag),
      .q_number        (q_number),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_last        (rsp_last),
      .rsp_digit_count (rsp_digit_count),
      .rsp_bad_base    (rsp_bad_base)
   );

   assign bad_form_ok   = rsp_last && rsp_digit_count == '0 && rsp_digit_char == '0;
   assign digit_char_ok = (rsp_digit_char >= Char0 && rsp_digit_char <= Char9) ||
                          (rsp_digit_char >= CharA && rsp_digit_char <= CharZ);
   assign good_char_ok  = rsp_digit_count != '0 && digit_char_ok;

   // a bad-base transfer is a single, empty, final result
   `RDC_ASSERT_IMPL(a_bad_form, clock, reset, rsp_valid && rsp_bad_base, bad_form_ok)

   // every good character is a legal digit and its count is nonzero
   `RDC_ASSERT_IMPL(a_good_char, clock, reset, rsp_valid && !rsp_bad_base, good_char_ok)

   // a full queue stays full until the converter pops it
   `RDC_ASSERT_NEXT(a_queue_hold, clock, reset, req_stall && !q_pop, req_stall)

endmodule

`default_nettype wire

FILE: rtl/rdc_front.sv
// Front end: classifies incoming numbers and holds them in a two-entry queue.
// Depends on rdc_pkg.
`default_nettype none

module rdc_front import rdc_pkg::*; #(
   parameter int NUMBER_WIDTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [NUMBER_WIDTH-1:0] req_number,
   input  wire logic [BaseWidth-1:0]    req_base,
   output logic                         q_valid,
   output tag_type                      q_tag,
   output logic [NUMBER_WIDTH-1:0]      q_number,
   input  wire logic                    q_pop
);

   logic [NUMBER_WIDTH-1:0]  num_mem_ff [QueueDepth];
   tag_type                  tag_mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrWidth:0]   fill_ff, fill_in;
   logic                     push;
   tag_type                  new_tag;

   always_comb begin
      new_tag.base = req_base;
      if (req_base < MinBase || req_base > MaxBase) begin
         new_tag.kind = KIND_BAD;
      end else if (req_number == '0) begin
         new_tag.kind = KIND_ZERO;
      end else begin
         new_tag.kind = KIND_CONVERT;
      end
   end

   assign req_stall = (fill_ff == (QueuePtrWidth+1)'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_tag     = tag_mem_ff[rd_ptr_ff];
   assign q_number  = num_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         num_mem_ff[wr_ptr_ff] <= req_number;
         tag_mem_ff[wr_ptr_ff] <= new_tag;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rdc_back.sv
// Back end: bit-serial divider, digit stack memory and character emitter.
// Depends on rdc_pkg.
`default_nettype none

module rdc_back import rdc_pkg::*; #(
   parameter int MAX_DIGITS   = 64,
   parameter int NUMBER_WIDTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   input  wire tag_type                 q_tag,
   input  wire logic [NUMBER_WIDTH-1:0] q_number,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [CharWidth-1:0]         rsp_digit_char,
   output logic                         rsp_last,
   output logic [DigitCountWidth-1:0]   rsp_digit_count,
   output logic                         rsp_bad_base
);

   localparam int IdxWidth = $clog2(MAX_DIGITS);
   localparam int CntWidth = $clog2(MAX_DIGITS + 1);
   localparam int BitWidth = $clog2(NUMBER_WIDTH);
   localparam logic [BitWidth-1:0] LastBit  = BitWidth'(NUMBER_WIDTH - 1);
   localparam logic [CntWidth-1:0] LastSlot = CntWidth'(MAX_DIGITS - 1);

   logic [DigitWidth-1:0] stack_mem [MAX_DIGITS];
   logic [DigitWidth-1:0] rd_data_ff;

   state_type                state_ff, state_in;
   logic [NUMBER_WIDTH-1:0]  quo_ff, quo_in;
   logic [DigitWidth-1:0]    rem_ff, rem_in;
   logic [BitWidth-1:0]      bit_ff, bit_in;
   logic [BaseWidth-1:0]     base_ff, base_in;
   logic [CntWidth-1:0]      cnt_ff, cnt_in;
   logic [IdxWidth-1:0]      rd_idx_ff, rd_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]     rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [DigitCountWidth-1:0] rsp_count_ff, rsp_count_in;
   logic                     rsp_bad_ff, rsp_bad_in;

   logic                     wr_en;
   logic [IdxWidth-1:0]      wr_addr;
   logic [DigitWidth-1:0]    wr_data;
   logic                     out_free;
   logic [DigitWidth:0]      trial;
   logic                     trial_ge;
   logic [DigitWidth:0]      trial_sub;
   logic [DigitWidth-1:0]    rem_next;
   logic [NUMBER_WIDTH-1:0]  quo_next;

   // one restoring-division step per cycle
   always_comb begin
      trial     = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
      trial_ge  = (trial >= {1'b0, base_ff});
      trial_sub = trial - {1'b0, base_ff};
      rem_next  = trial_ge ? trial_sub[DigitWidth-1:0] : trial[DigitWidth-1:0];
      quo_next  = {quo_ff[NUMBER_WIDTH-2:0], trial_ge};
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in   = rsp_bad_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[IdxWidth-1:0];
      wr_data      = rem_next;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_tag.kind)
                  KIND_BAD: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_char_in  = '0;
                        rsp_last_in  = 1'b1;
                        rsp_count_in = '0;
                        rsp_bad_in   = 1'b1;
                     end
                  end
                  KIND_ZERO: begin
                     q_pop     = 1'b1;
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     wr_data   = '0;
                     cnt_in    = CntWidth'(1);
                     rd_idx_in = '0;
                     state_in  = ST_READ;
                  end
                  KIND_CONVERT: begin
                     q_pop    = 1'b1;
                     quo_in   = q_number;
                     rem_in   = '0;
                     bit_in   = '0;
                     base_in  = q_tag.base;
                     cnt_in   = '0;
                     state_in = ST_DIV;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV: begin
            quo_in = quo_next;
            rem_in = rem_next;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == LastBit) begin
               // digit done: push remainder, restart on the quotient
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               rem_in = '0;
               bit_in = '0;
               if (quo_next == '0 || cnt_ff == LastSlot) begin
                  rd_idx_in = cnt_ff[IdxWidth-1:0];
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_to_ascii(rd_data_ff);
               rsp_last_in  = (rd_idx_ff == '0);
               rsp_count_in = DigitCountWidth'(cnt_ff);
               rsp_bad_in   = 1'b0;
               if (rd_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      base_ff      <= base_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // digit stack: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_idx_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digit_char  = rsp_char_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_digit_count = rsp_count_ff;
   assign rsp_bad_base    = rsp_bad_ff;

endmodule

`default_nettype wire

FILE: verif/radix_digit_converter_tb.sv
// Testbench for radix_digit_converter: number/base transfers in, ASCII digit transfers out.
// Depends on rdc_pkg and the converter RTL; a local digit predictor checks every character.

module radix_digit_converter_tb import rdc_pkg::*;;

   localparam int NumWidth   = 64;
   localparam int MaxDigits  = 64;
   // no transfer on either side for this long means the block is hung; the slowest
   // legal gap is one 64-digit divide plus a long output hold
   localparam int QuietLimit = 50000;
   // longest drain after the last character: a full 64-digit conversion
   localparam int TailCycles = 4300;
   // longer than the slowest short-number divide, so the output side backs up
   localparam int HoldCycles = 2000;

   typedef struct packed {
      logic [NumWidth-1:0]  number;
      logic [BaseWidth-1:0] base;
   } number_item_type;

   typedef struct packed {
      logic [CharWidth-1:0]       ch;
      logic                       last;
      logic [DigitCountWidth-1:0] count;
      logic                       bad;
   } digit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid  = 1'b0;
   logic                       req_stall;
   logic [NumWidth-1:0]        req_number = '0;
   logic [BaseWidth-1:0]       req_base   = '0;
   logic                       rsp_valid;
   logic                       rsp_stall  = 1'b0;
   logic [CharWidth-1:0]       rsp_digit_char;
   logic                       rsp_last;
   logic [DigitCountWidth-1:0] rsp_digit_count;
   logic                       rsp_bad_base;

   number_item_type  pending_numbers[$];
   digit_result_type expected_chars[$];

   // predictor state: digit count of the last good conversion
   logic [DigitCountWidth-1:0] held_digits = '0;

   // idling knobs, written only by the sequencing block
   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit long_hold_req = 1'b0;

   // owned by the receiver process
   bit long_hold_done = 1'b0;
   int hold_left      = 0;

   int mismatch_count = 0;
   int quiet_cycles   = 0;

   radix_digit_converter #(
      .MAX_DIGITS   (MaxDigits),
      .NUMBER_WIDTH (NumWidth)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_number      (req_number),
      .req_base        (req_base),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_last        (rsp_last),
      .rsp_digit_count (rsp_digit_count),
      .rsp_bad_base    (rsp_bad_base)
   );

   always #1 clock = ~clock;

   // Works out the characters one accepted number produces and queues them.
   // Divides repeatedly, keeps remainders least significant first, then emits
   // them in reverse so the most significant digit leads.
   function automatic void predict_digits(logic [NumWidth-1:0] number,
                                          logic [BaseWidth-1:0] base);
      logic [63:0]           value;
      logic [63:0]           radix;
      logic [DigitWidth-1:0] rems [MaxDigits];
      logic [DigitWidth-1:0] d;
      int                    n;
      digit_result_type      r;
      value = 64'(number);
      if (NumWidth < 64) begin
         value = value & ((64'd1 << NumWidth) - 64'd1);
      end
      radix = 64'(base);
      n = 0;
      // out-of-range radix: one flagged result, held count untouched
      if (base < MinBase || base > MaxBase) begin
         r.ch    = '0;
         r.last  = 1'b1;
         r.count = '0;
         r.bad   = 1'b1;
         expected_chars.push_back(r);
         return;
      end
      if (value == 64'd0) begin
         // zero still yields one '0' digit
         rems[0] = '0;
         n = 1;
      end else begin
         // stops at MaxDigits divisions if the stack is too shallow
         while (value != 64'd0 && n < MaxDigits) begin
            rems[n] = DigitWidth'(value % radix);
            value   = value / radix;
            n++;
         end
      end
      held_digits = DigitCountWidth'(n);
      for (int k = 0; k < n; k++) begin
         d = rems[n - 1 - k];
         if (d >= Ten) begin
            r.ch = CharA + CharWidth'(d - Ten);
         end else begin
            r.ch = Char0 + CharWidth'(d);
         end
         r.last  = (k == n - 1);
         r.count = held_digits;
         r.bad   = 1'b0;
         expected_chars.push_back(r);
      end
   endfunction

   task automatic add_number(logic [NumWidth-1:0] number, logic [BaseWidth-1:0] base);
      number_item_type it;
      it.number = number;
      it.base   = base;
      pending_numbers.push_back(it);
   endtask

   // Random item: mostly short numbers so the divider stays quick, a quarter long ones
   // (none when short_only), a few zeros and a few out-of-range bases.
   task automatic add_random_numbers(int count, bit short_only);
      logic [63:0]          number;
      logic [BaseWidth-1:0] base;
      int                   len;
      int                   roll;
      repeat (count) begin
         number = {$urandom(), $urandom()};
         if (!short_only && $urandom_range(3, 0) == 0) begin
            len = $urandom_range(64, 33);
         end else begin
            len = $urandom_range(short_only ? 16 : 32, 1);
         end
         if (len < 64) begin
            number = number & ((64'd1 << len) - 64'd1);
         end
         if ($urandom_range(19, 0) == 0) begin
            number = '0;
         end
         roll = $urandom_range(99, 0);
         if (roll < 8) begin
            base = $urandom_range(1, 0) ? BaseWidth'($urandom_range(1, 0))
                                        : BaseWidth'($urandom_range(63, 37));
         end else begin
            base = BaseWidth'($urandom_range(36, 2));
         end
         add_number(NumWidth'(number), base);
      end
   endtask

   // Sender pause: nothing queued, nothing offered, every character back.
   task automatic wait_drained();
      while (pending_numbers.size() != 0 || req_valid || expected_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Driver: a transfer happens on valid && !stall; the next number is only
   // offered once the current one is taken, so a stalled payload holds still.
   always @(posedge clock) begin : number_driver
      number_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_digits(req_number, req_base);
         end
         if (!req_valid || !req_stall) begin
            if (pending_numbers.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               it = pending_numbers.pop_front();
               req_valid  <= 1'b1;
               req_number <= it.number;
               req_base   <= it.base;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random per cycle, or one long hold-off when asked,
   // counted here so the input side backs up behind it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_left      <= HoldCycles;
         rsp_stall      <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   // Monitor: each character transfer against the oldest expectation.
   always @(posedge clock) begin : char_monitor
      digit_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected char: got char %h last %b count %0d bad %b",
                        rsp_digit_char, rsp_last, rsp_digit_count, rsp_bad_base);
            end
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_digit_char !== want.ch || rsp_last !== want.last ||
                rsp_digit_count !== want.count || rsp_bad_base !== want.bad) begin
               if (mismatch_count < 10) begin
                  $display("char mismatch: exp %h/%b/%0d/%b got %h/%b/%0d/%b",
                           want.ch, want.last, want.count, want.bad,
                           rsp_digit_char, rsp_last, rsp_digit_count, rsp_bad_base);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: cycles without a transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sequencing: directed numbers, then random phases under each idling mix,
   // with a full drain between phases.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: zeros, extremes, every bad-base region, digit-letter edges
      add_number('0, 6'd10);
      add_number('0, MinBase);
      add_number('0, 6'd0);                       // bad base wins over zero
      add_number('1, MinBase);                    // all 64 digits
      add_number('1, 6'd3);
      add_number('1, 6'd10);
      add_number('1, 6'd16);
      add_number('1, MaxBase);
      add_number('1, 6'd63);                      // all base bits set, bad
      add_number(64'd1, MinBase);
      add_number(64'h8000_0000_0000_0000, MinBase);
      add_number(64'd9, 6'd10);                   // '9'
      add_number(64'd10, 6'd11);                  // 'A'
      add_number(64'd35, MaxBase);                // 'Z'
      add_number(64'd36, MaxBase);                // "10"
      add_number(64'd12345678901234567890, 6'd10);
      add_number(64'hFEDC_BA98_7654_3210, 6'd16);
      add_number(64'hAAAA_AAAA_AAAA_AAAA, 6'd5);
      add_number(64'h5555_5555_5555_5555, 6'd7);
      add_number(64'h0123_4567_89AB_CDEF, 6'd1);  // just below range
      add_number(64'hDEAD_BEEF_0000_0001, 6'd37); // just above range
      wait_drained();

      // no idling
      add_random_numbers(22, 1'b0);
      wait_drained();

      // long output hold-off while the sender keeps offering short numbers
      long_hold_req = 1'b1;
      add_random_numbers(12, 1'b1);
      wait_drained();

      send_idle_pct = 56;
      stall_pct     = 0;
      add_random_numbers(22, 1'b0);
      wait_drained();

      send_idle_pct = 0;
      stall_pct     = 56;
      add_random_numbers(22, 1'b0);
      wait_drained();

      send_idle_pct = 22;
      stall_pct     = 22;
      add_random_numbers(22, 1'b0);
      wait_drained();

      // anything arriving now is an extra character
      repeat (TailCycles) @(posedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
